// ===== hdl/nlt_pkg.sv =====
// ----------------------------------------------------------------------------
// nlt_pkg
// Shared constants, command codes and control types of the node liveness table.
// ----------------------------------------------------------------------------
package nlt_pkg;

	// Table geometry. Stamps are stored as rows of eight lanes, one row per bitmap byte.
	localparam int NODE_COUNT   = 256;
	localparam int TABLE_DEPTH  = 256;
	localparam int LANES        = 8;
	localparam int BITMAP_BYTES = TABLE_DEPTH / LANES;
	localparam int ROW_W        = $clog2(BITMAP_BYTES);
	localparam int LANE_W       = $clog2(LANES);
	localparam int NODE_W       = 8;
	localparam int STAMP_W      = 32;

	// Nodes that a touch never marks as seen.
	localparam logic [NODE_W-1:0] RESERVED_LOW  = 8'd0;
	localparam logic [NODE_W-1:0] RESERVED_HIGH = 8'd255;

	// Command codes of an input item.
	localparam logic [1:0] CMD_TICK      = 2'd0;
	localparam logic [1:0] CMD_TOUCH     = 2'd1;
	localparam logic [1:0] CMD_QUERY     = 2'd2;
	localparam logic [1:0] CMD_SERIALISE = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             do_tick;
		logic             do_touch;
		logic             issue_rd;
		logic             rd_ser;
		logic [ROW_W-1:0] rd_row;
		logic             rd_last;
	} nlt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic adv;
	} nlt_stat_t;

endpackage

// ===== hdl/node_liveness_table_unit.sv =====
// ----------------------------------------------------------------------------
// node_liveness_table_unit
// A query answer or the first bitmap byte passes through the read stage into the
// output register; tick and touch act at the accepting edge. One tick, touch or
// query per cycle while the output is not stalled; a serialise run emits 32 bytes
// one per cycle while the output is not stalled, and no new item is accepted until
// the run has issued its last row read through the one row read port of the stamp
// memory. Reset clears uptime, cutoff, seen flags and the previous bitmap at once;
// stamps are not reset and count only when seen.
module node_liveness_table_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [31:0]                cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic [nlt_pkg::NODE_W-1:0] node,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       is_fresh,
	output logic [7:0]                 bitmap_byte,
	output logic [4:0]                 byte_index,
	output logic                       changed,
	output logic                       last
);

	nlt_pkg::nlt_cmd_t  cmd;
	nlt_pkg::nlt_stat_t stat;

	// Controller.
	nlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Datapath.
	nlt_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.node        (node),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_fresh    (is_fresh),
		.bitmap_byte (bitmap_byte),
		.byte_index  (byte_index),
		.changed     (changed),
		.last        (last)
	);

endmodule

// ===== hdl/nlt_ctrl.sv =====
// ----------------------------------------------------------------------------
// nlt_ctrl
// Controller: accepts input items and sequences the row reads of a serialise run.
// ----------------------------------------------------------------------------
module nlt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	output nlt_pkg::nlt_cmd_t  cmd,
	input  nlt_pkg::nlt_stat_t stat
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SER  = 1'b1;

	logic                      state_q;
	logic [nlt_pkg::ROW_W-1:0] cnt_q;
	logic                      accept;
	logic                      ser_last;

	// New items are taken only between serialise runs and when the read stage can move.
	assign in_ready = (state_q == ST_IDLE) && stat.adv;
	assign accept   = in_valid && in_ready;
	assign ser_last = (cnt_q == nlt_pkg::ROW_W'(nlt_pkg::BITMAP_BYTES - 1));

	// Command decode.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (command)
						nlt_pkg::CMD_TICK: begin
							cmd.do_tick = 1'b1;
						end
						nlt_pkg::CMD_TOUCH: begin
							cmd.do_touch = 1'b1;
						end
						nlt_pkg::CMD_QUERY: begin
							cmd.issue_rd = 1'b1;
							cmd.rd_last  = 1'b1;
						end
						nlt_pkg::CMD_SERIALISE: begin
							cmd.issue_rd = 1'b1;
							cmd.rd_ser   = 1'b1;
							cmd.rd_row   = '0;
						end
						default: begin
							cmd = '0;
						end
					endcase
				end
			end
			ST_SER: begin
				cmd.issue_rd = stat.adv;
				cmd.rd_ser   = 1'b1;
				cmd.rd_row   = cnt_q;
				cmd.rd_last  = ser_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and row counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && command == nlt_pkg::CMD_SERIALISE) begin
						state_q <= ST_SER;
						cnt_q   <= nlt_pkg::ROW_W'(1);
					end
				end
				ST_SER: begin
					if (stat.adv) begin
						cnt_q <= cnt_q + nlt_pkg::ROW_W'(1);
						if (ser_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A serialise run blocks new items.
	a_ser_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SER |-> !in_ready)
		else $error("input accepted during a serialise run");

	// Byte zero is issued from idle, so the counter never reads zero during a run.
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SER |-> cnt_q != '0)
		else $error("serialise row counter out of step");

	// Issuing the final serialise row ends the run.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SER && cmd.issue_rd && cmd.rd_last |=> state_q == ST_IDLE)
		else $error("serialise run did not end after the last row");

endmodule

// ===== hdl/nlt_datapath.sv =====
// ----------------------------------------------------------------------------
// nlt_datapath
// Datapath: uptime counter, seen flags, stamp memory, freshness compare,
// previous bitmap and the output register.
// ----------------------------------------------------------------------------
module nlt_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [31:0]                      cfg_data,
	input  logic [nlt_pkg::NODE_W-1:0]       node,
	input  nlt_pkg::nlt_cmd_t                cmd,
	output nlt_pkg::nlt_stat_t               stat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             is_fresh,
	output logic [7:0]                       bitmap_byte,
	output logic [4:0]                       byte_index,
	output logic                             changed,
	output logic                             last
);

	localparam int LANES   = nlt_pkg::LANES;
	localparam int STAMP_W = nlt_pkg::STAMP_W;
	localparam int ROW_W   = nlt_pkg::ROW_W;
	localparam int LANE_W  = nlt_pkg::LANE_W;

	// Architectural state.
	logic [STAMP_W-1:0]                 uptime_q;
	logic [31:0]                        cutoff_q;
	logic [nlt_pkg::TABLE_DEPTH-1:0]    seen_q;
	logic [LANES-1:0][STAMP_W-1:0]      stamp_mem [nlt_pkg::BITMAP_BYTES];
	logic [LANES-1:0]                   prev_q [nlt_pkg::BITMAP_BYTES];
	logic                               chg_acc_q;

	// Read stage.
	logic                               valid_s1;
	logic [LANES-1:0][STAMP_W-1:0]      stamps_s1;
	logic [LANES-1:0]                   seen_s1;
	logic                               all_fresh_s1;
	logic [STAMP_W-1:0]                 thresh_s1;
	logic                               ser_s1;
	logic [ROW_W-1:0]                   row_s1;
	logic [LANE_W-1:0]                  lane_s1;
	logic                               last_s1;

	// Output register.
	logic                               out_valid_q;
	logic                               is_fresh_q;
	logic [7:0]                         bitmap_byte_q;
	logic [4:0]                         byte_index_q;
	logic                               changed_q;
	logic                               last_q;

	logic                               out_load;
	logic                               adv;
	logic                               touch_ok;
	logic [ROW_W-1:0]                   rd_row;
	logic [LANES-1:0]                   seen_row;
	logic [LANES-1:0]                   fresh_bits;
	logic                               diff;
	logic                               chg_next;

	// Pipeline flow: the read stage moves when it is empty or drains into the output.
	assign out_load = valid_s1 && (!out_valid_q || out_ready);
	assign adv      = !valid_s1 || out_load;
	assign stat.adv = adv;

	// Touch is ignored for the reserved nodes and for nodes outside the table.
	assign touch_ok = (node != nlt_pkg::RESERVED_LOW) && (node != nlt_pkg::RESERVED_HIGH)
		&& ({1'b0, node} < 9'(nlt_pkg::NODE_COUNT));

	// All lanes share one read row: the serialise counter or the queried node's row.
	assign rd_row = cmd.rd_ser ? cmd.rd_row : node[nlt_pkg::NODE_W-1:LANE_W];

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			seen_row[j] = seen_q[{rd_row, LANE_W'(j)}];
		end
	end

	// Uptime, cutoff register and seen flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uptime_q <= '0;
			cutoff_q <= '0;
			seen_q   <= '0;
		end else begin
			if (cfg_we) begin
				cutoff_q <= cfg_data;
			end
			if (cmd.do_tick && uptime_q != {STAMP_W{1'b1}}) begin
				uptime_q <= uptime_q + STAMP_W'(1);
			end
			if (cmd.do_touch && touch_ok) begin
				seen_q[node] <= 1'b1;
			end
		end
	end

	// Stamp memory: one lane written per touch, one row read per issue.
	always_ff @(posedge clk) begin
		if (cmd.do_touch && touch_ok) begin
			stamp_mem[node[nlt_pkg::NODE_W-1:LANE_W]][node[LANE_W-1:0]] <= uptime_q;
		end
		if (cmd.issue_rd && adv) begin
			stamps_s1 <= stamp_mem[rd_row];
		end
	end

	// Read stage control and captured context.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cmd.issue_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cmd.issue_rd) begin
			seen_s1      <= seen_row;
			all_fresh_s1 <= (uptime_q <= cutoff_q);
			thresh_s1    <= uptime_q - cutoff_q;
			ser_s1       <= cmd.rd_ser;
			row_s1       <= rd_row;
			lane_s1      <= node[LANE_W-1:0];
			last_s1      <= cmd.rd_last;
		end
	end

	// Freshness of the eight nodes in the row.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			fresh_bits[j] = seen_s1[j] && (all_fresh_s1 || (stamps_s1[j] > thresh_s1));
		end
	end

	// Change tracking against the previously emitted bitmap.
	assign diff     = (fresh_bits != prev_q[row_s1]);
	assign chg_next = ((row_s1 == '0) ? 1'b0 : chg_acc_q) | diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < nlt_pkg::BITMAP_BYTES; b++) begin
				prev_q[b] <= '0;
			end
			chg_acc_q <= 1'b0;
		end else if (out_load && ser_s1) begin
			prev_q[row_s1] <= fresh_bits;
			chg_acc_q      <= chg_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (ser_s1) begin
				is_fresh_q    <= 1'b0;
				bitmap_byte_q <= fresh_bits;
				byte_index_q  <= 5'(row_s1);
				changed_q     <= last_s1 && chg_next;
				last_q        <= last_s1;
			end else begin
				is_fresh_q    <= fresh_bits[lane_s1];
				bitmap_byte_q <= '0;
				byte_index_q  <= '0;
				changed_q     <= 1'b0;
				last_q        <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign is_fresh    = is_fresh_q;
	assign bitmap_byte = bitmap_byte_q;
	assign byte_index  = byte_index_q;
	assign changed     = changed_q;
	assign last        = last_q;

	// A filled read stage reaches an empty output register in the next cycle.
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("read stage did not drain into an empty output register");

	// Results that are not final are serialise bytes and carry no query answer.
	a_mid_no_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> !is_fresh_q && !changed_q)
		else $error("non-final result carries query or change flag");

	// The change flag appears only on the final bitmap byte.
	a_chg_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && changed_q |-> last_q && byte_index_q == 5'(nlt_pkg::BITMAP_BYTES - 1))
		else $error("change flag on a byte other than the last");

endmodule
